// ----- rtl/lav_pkg.sv -----
`timescale 1ns / 1ps

package lav_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int FIELD_W = 32;
    localparam int ROW_W   = 2;
    localparam int NROWS   = 4;

    // A prescaled vector has its largest magnitude in [2^29, 2^30).
    localparam int PS_MAG_W = 30;
    localparam int PS_LEAD  = 29;
    localparam int PRE_LAT  = 3;

    // Sum of three prescaled squares and its integer square root.
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;

    typedef logic [ROW_W-1:0] row_t;

    localparam row_t ROW_RIGHT = 2'd0;
    localparam row_t ROW_UP    = 2'd1;
    localparam row_t ROW_BACK  = 2'd2;
    localparam row_t ROW_CONST = 2'd3;

    typedef struct packed {
        logic                         zero;
        logic [2:0]                   neg;
        logic [2:0][PS_MAG_W-1:0]     mag;
    } pvec_t;

    function automatic int norm_lat(input int frac);
        return frac + ROOT_W + 5;
    endfunction

endpackage

// ----- rtl/lav_delay.sv -----
`timescale 1ns / 1ps

module lav_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [D];

    genvar k;
    generate
        for (k = 0; k < D; k++) begin : g_tap
            if (k == 0) begin : g_first
                always_ff @(posedge clk)
                begin
                    line_reg[k] <= din;
                end
            end else begin : g_rest
                always_ff @(posedge clk)
                begin
                    line_reg[k] <= line_reg[k-1];
                end
            end
        end
    endgenerate

    assign dout = line_reg[D-1];

endmodule

// ----- rtl/lav_prescale.sv -----
`timescale 1ns / 1ps

module lav_prescale #(
    parameter int IW = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [IW-1:0]  in_vec [3],
    output logic                  out_valid,
    output lav_pkg::pvec_t        out_vec
);

    localparam int PW = $clog2(IW);
    localparam int XW = IW + lav_pkg::PS_MAG_W;
    localparam int MW = lav_pkg::PS_MAG_W;

    logic [IW-1:0] u1_reg [3];
    logic [2:0]    n1_reg;
    logic [IW-1:0] m1_reg;
    logic          v1_reg;

    logic [IW-1:0] u2_reg [3];
    logic [2:0]    n2_reg;
    logic [PW-1:0] p2_reg;
    logic          z2_reg;
    logic          v2_reg;

    logic [IW-1:0] u1_next [3];
    logic [IW-1:0] m1_next;
    logic [PW-1:0] p2_next;
    lav_pkg::pvec_t vec_next;
    lav_pkg::pvec_t vec_reg;
    logic           v3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u1_next[i] = in_vec[i][IW-1] ? $unsigned(-in_vec[i]) : $unsigned(in_vec[i]);
        end
        m1_next = u1_next[0];
        if (u1_next[1] > m1_next)
        begin
            m1_next = u1_next[1];
        end
        if (u1_next[2] > m1_next)
        begin
            m1_next = u1_next[2];
        end
    end

    always_comb
    begin
        p2_next = '0;
        for (int b = 0; b < IW; b++)
        begin
            if (m1_reg[b])
            begin
                p2_next = PW'(b);
            end
        end
    end

    always_comb
    begin
        logic [XW-1:0] x;
        x = '0;
        vec_next.zero = z2_reg;
        vec_next.neg  = n2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (p2_reg > lav_pkg::PS_LEAD)
            begin
                x = XW'(u2_reg[i]) >> (p2_reg - lav_pkg::PS_LEAD);
            end else begin
                x = XW'(u2_reg[i]) << (lav_pkg::PS_LEAD - p2_reg);
            end
            vec_next.mag[i] = x[MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u1_reg[i] <= u1_next[i];
            n1_reg[i] <= in_vec[i][IW-1];
            u2_reg[i] <= u1_reg[i];
        end
        m1_reg  <= m1_next;
        n2_reg  <= n1_reg;
        p2_reg  <= p2_next;
        z2_reg  <= (m1_reg == '0);
        vec_reg <= vec_next;
    end

    assign out_valid = v3_reg;
    assign out_vec   = vec_reg;

endmodule

// ----- rtl/lav_normalize.sv -----
`timescale 1ns / 1ps

module lav_normalize #(
    parameter int FRAC = lav_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  lav_pkg::pvec_t        in_vec,
    output logic                  out_valid,
    output logic signed [FRAC+1:0] out_axis [3],
    output logic                  out_degen
);

    localparam int MW  = lav_pkg::PS_MAG_W;
    localparam int S1W = 2 * MW;
    localparam int SQW = lav_pkg::SQ_W;
    localparam int RW  = lav_pkg::ROOT_W;
    localparam int TW  = SQW + 2;
    localparam int QW  = FRAC + 1;
    localparam int DW  = RW + FRAC + 1;
    localparam int AXW = FRAC + 2;

    logic [S1W-1:0]  sq_reg [3];
    lav_pkg::pvec_t  sq_vec_reg;
    logic            sq_valid_reg;

    logic [SQW-1:0]  sum_reg;
    lav_pkg::pvec_t  sum_vec_reg;
    logic            sum_valid_reg;

    logic [SQW-1:0]  rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    lav_pkg::pvec_t  rvec_reg [RW];
    logic            rval_reg [RW];

    logic [DW-1:0]   num_reg [3];
    logic [RW-1:0]   len_reg;
    lav_pkg::pvec_t  nvec_reg;
    logic            nval_reg;

    logic [DW-1:0]   dr_reg   [QW][3];
    logic [QW-1:0]   q_reg    [QW][3];
    logic [RW-1:0]   dlen_reg [QW];
    lav_pkg::pvec_t  dvec_reg [QW];
    logic            dval_reg [QW];

    logic signed [AXW-1:0] axis_reg [3];
    logic                  degen_reg;
    logic                  oval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            nval_reg      <= 1'b0;
            oval_reg      <= 1'b0;
        end else begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
            nval_reg      <= rval_reg[RW-1];
            oval_reg      <= dval_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= S1W'(in_vec.mag[i]) * S1W'(in_vec.mag[i]);
        end
        sq_vec_reg  <= in_vec;
        sum_reg     <= SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
        sum_vec_reg <= sq_vec_reg;
    end

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_root
            localparam int B = RW - 1 - k;
            logic [SQW-1:0]  rem_in;
            logic [RW-1:0]   root_in;
            lav_pkg::pvec_t  vec_in;
            logic            val_in;
            logic [TW-1:0]   trial;
            logic            fits;

            if (k == 0) begin : g_first
                assign rem_in  = sum_reg;
                assign root_in = '0;
                assign vec_in  = sum_vec_reg;
                assign val_in  = sum_valid_reg;
            end else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign vec_in  = rvec_reg[k-1];
                assign val_in  = rval_reg[k-1];
            end

            assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
            assign fits  = TW'(rem_in) >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rval_reg[k] <= 1'b0;
                end else begin
                    rval_reg[k] <= val_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= fits ? SQW'(TW'(rem_in) - trial) : rem_in;
                root_reg[k] <= fits ? (root_in | (RW'(1) << B)) : root_in;
                rvec_reg[k] <= vec_in;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= (DW'(rvec_reg[RW-1].mag[i]) << FRAC) + DW'(root_reg[RW-1] >> 1);
        end
        len_reg  <= root_reg[RW-1];
        nvec_reg <= rvec_reg[RW-1];
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_div
            localparam int B = FRAC - j;
            logic [DW-1:0]   dr_in [3];
            logic [QW-1:0]   q_in  [3];
            logic [RW-1:0]   len_in;
            lav_pkg::pvec_t  vec_in;
            logic            val_in;
            logic [DW-1:0]   dsor;

            if (j == 0) begin : g_first
                assign dr_in  = num_reg;
                assign q_in   = '{default: '0};
                assign len_in = len_reg;
                assign vec_in = nvec_reg;
                assign val_in = nval_reg;
            end else begin : g_rest
                assign dr_in  = dr_reg[j-1];
                assign q_in   = q_reg[j-1];
                assign len_in = dlen_reg[j-1];
                assign vec_in = dvec_reg[j-1];
                assign val_in = dval_reg[j-1];
            end

            assign dsor = DW'(len_in) << B;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dval_reg[j] <= 1'b0;
                end else begin
                    dval_reg[j] <= val_in;
                end
            end

            always_ff @(posedge clk)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (dr_in[l] >= dsor)
                    begin
                        dr_reg[j][l] <= dr_in[l] - dsor;
                        q_reg[j][l]  <= q_in[l] | (QW'(1) << B);
                    end else begin
                        dr_reg[j][l] <= dr_in[l];
                        q_reg[j][l]  <= q_in[l];
                    end
                end
                dlen_reg[j] <= len_in;
                dvec_reg[j] <= vec_in;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dvec_reg[QW-1].zero)
            begin
                axis_reg[l] <= '0;
            end else if (dvec_reg[QW-1].neg[l])
            begin
                axis_reg[l] <= -signed'({1'b0, q_reg[QW-1][l]});
            end else begin
                axis_reg[l] <= signed'({1'b0, q_reg[QW-1][l]});
            end
        end
        degen_reg <= dvec_reg[QW-1].zero;
    end

    assign out_valid = oval_reg;
    assign out_axis  = axis_reg;
    assign out_degen = degen_reg;

endmodule

// ----- rtl/look_at_view_matrix.sv -----
// Rows: the row sequencer puts row 0 on the ports first and then rows 1 to 3 in order.
// Start is accepted only while busy is low, since the four row beats share the one result
// channel; busy rises after each accepted item and falls as bcnt_reg counts down to zero.
// Reset clears the row sequencer and every valid bit but the copy of the up valid in its
// delay line, which is only used ANDed with the reset backward-axis valid; no clearing pass is needed.
`timescale 1ns / 1ps

module look_at_view_matrix #(
    parameter int FRAC_BITS   = lav_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               row_valid,
    output logic [1:0]         row_index,
    output logic signed [31:0] elem_0,
    output logic signed [31:0] elem_1,
    output logic signed [31:0] elem_2,
    output logic signed [31:0] elem_3,
    output logic               degenerate,
    output logic               last_row
);

    localparam int CW    = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int FW    = lav_pkg::FIELD_W;
    localparam int NL    = lav_pkg::norm_lat(F);
    localparam int PL    = lav_pkg::PRE_LAT;
    localparam int ZW    = F + 2;
    localparam int UW    = lav_pkg::PS_MAG_W + 1;
    localparam int CPW   = UW + ZW;
    localparam int CXW   = CPW + 1;
    localparam int YPW   = 2 * ZW;
    localparam int YSW   = YPW + 1;
    localparam int AW    = F + 5;
    localparam int EL    = CW / 2;
    localparam int EH    = CW - EL;
    localparam int PLW   = AW + EL + 1;
    localparam int PHW   = AW + EH;
    localparam int DOTW  = AW + CW + 2;
    localparam int SATW  = DOTW + 1;
    localparam int T1    = PL + NL;
    localparam int T2    = T1 + 2 + PL + NL;
    localparam int EYE_DLY = T2 + 2;
    localparam int Z_DLY   = T2 - T1;
    localparam int NR    = lav_pkg::NROWS;

    localparam logic signed [SATW-1:0] SAT_HI = {{(SATW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SATW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [DOTW-1:0] DOT_HALF = DOTW'(1) << (F - 1);
    localparam logic signed [YSW-1:0]  Y_HALF   = YSW'(1) << (F - 1);
    localparam logic [CW-1:0] ONE_SAT = (F > CW - 2) ? CW'((64'd1 << (CW - 1)) - 64'd1)
                                                     : CW'(64'd1 << F);

    function automatic logic signed [CW-1:0] to_coord(input logic [FW-1:0] f);
        logic [63:0] e;
        e = {32'b0, f};
        return signed'(e[CW-1:0]);
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] s;
        s = v;
        if (v > SAT_HI)
        begin
            s = SAT_HI;
        end else if (v < SAT_LO)
        begin
            s = SAT_LO;
        end
        return signed'(s[CW-1:0]);
    endfunction

    function automatic logic [FW-1:0] to_field(input logic signed [CW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[FW-1:0];
    endfunction

    // Input registers.
    logic [1:0]             bcnt_reg;
    logic                   accept;
    logic signed [CW-1:0]   eye_in [3];
    logic signed [CW-1:0]   eye_reg [3];
    logic signed [CW:0]     d_reg [3];
    logic signed [CW-1:0]   up_reg [3];
    logic                   v0_reg;

    assign busy   = (bcnt_reg != 2'd0);
    assign accept = start && !busy;

    assign eye_in[0] = to_coord(eye_x);
    assign eye_in[1] = to_coord(eye_y);
    assign eye_in[2] = to_coord(eye_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg <= 2'd0;
            v0_reg   <= 1'b0;
        end else begin
            v0_reg <= accept;
            if (accept)
            begin
                bcnt_reg <= 2'(NR - 1);
            end else if (bcnt_reg != 2'd0)
            begin
                bcnt_reg <= bcnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg <= eye_in;
        d_reg[0] <= (CW+1)'(eye_in[0]) - (CW+1)'(to_coord(target_x));
        d_reg[1] <= (CW+1)'(eye_in[1]) - (CW+1)'(to_coord(target_y));
        d_reg[2] <= (CW+1)'(eye_in[2]) - (CW+1)'(to_coord(target_z));
        up_reg[0] <= to_coord(up_x);
        up_reg[1] <= to_coord(up_y);
        up_reg[2] <= to_coord(up_z);
    end

    // Backward axis and prescaled up.
    logic                   pd_valid;
    lav_pkg::pvec_t         pd_vec;
    logic                   pu_valid;
    lav_pkg::pvec_t         pu_vec;
    logic                   z_valid;
    logic signed [ZW-1:0]   z_axis [3];
    logic                   z_degen;

    lav_prescale #(.IW(CW + 1)) u_pre_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_vec    (d_reg),
        .out_valid (pd_valid),
        .out_vec   (pd_vec)
    );

    lav_prescale #(.IW(CW)) u_pre_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_vec    (up_reg),
        .out_valid (pu_valid),
        .out_vec   (pu_vec)
    );

    lav_normalize #(.FRAC(F)) u_norm_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pd_valid),
        .in_vec    (pd_vec),
        .out_valid (z_valid),
        .out_axis  (z_axis),
        .out_degen (z_degen)
    );

    logic signed [UW-1:0]   ups_s [3];
    logic [3*UW:0]          ups_line_in;
    logic [3*UW:0]          ups_line_out;
    logic signed [UW-1:0]   ups_d [3];
    logic                   ups_valid_d;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ups_s[i] = pu_vec.neg[i] ? -signed'({1'b0, pu_vec.mag[i]})
                                     : signed'({1'b0, pu_vec.mag[i]});
        end
    end

    assign ups_line_in = {pu_valid, ups_s[2], ups_s[1], ups_s[0]};

    lav_delay #(.W(3 * UW + 1), .D(NL)) u_dly_up (
        .clk  (clk),
        .din  (ups_line_in),
        .dout (ups_line_out)
    );

    assign ups_d[0]    = signed'(ups_line_out[UW-1:0]);
    assign ups_d[1]    = signed'(ups_line_out[2*UW-1:UW]);
    assign ups_d[2]    = signed'(ups_line_out[3*UW-1:2*UW]);
    assign ups_valid_d = ups_line_out[3*UW];

    // Cross product up x backward.
    logic signed [CPW-1:0]  cp_reg [6];
    logic                   c1_valid_reg;
    logic signed [CXW-1:0]  c_reg [3];
    logic                   c2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end else begin
            c1_valid_reg <= z_valid && ups_valid_d;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg[0] <= CPW'(ups_d[1]) * CPW'(z_axis[2]);
        cp_reg[1] <= CPW'(ups_d[2]) * CPW'(z_axis[1]);
        cp_reg[2] <= CPW'(ups_d[2]) * CPW'(z_axis[0]);
        cp_reg[3] <= CPW'(ups_d[0]) * CPW'(z_axis[2]);
        cp_reg[4] <= CPW'(ups_d[0]) * CPW'(z_axis[1]);
        cp_reg[5] <= CPW'(ups_d[1]) * CPW'(z_axis[0]);
        c_reg[0]  <= CXW'(cp_reg[0]) - CXW'(cp_reg[1]);
        c_reg[1]  <= CXW'(cp_reg[2]) - CXW'(cp_reg[3]);
        c_reg[2]  <= CXW'(cp_reg[4]) - CXW'(cp_reg[5]);
    end

    // Right axis.
    logic                   pc_valid;
    lav_pkg::pvec_t         pc_vec;
    logic                   x_valid;
    logic signed [ZW-1:0]   x_axis [3];
    logic                   x_degen;

    lav_prescale #(.IW(CXW)) u_pre_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c2_valid_reg),
        .in_vec    (c_reg),
        .out_valid (pc_valid),
        .out_vec   (pc_vec)
    );

    lav_normalize #(.FRAC(F)) u_norm_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pc_valid),
        .in_vec    (pc_vec),
        .out_valid (x_valid),
        .out_axis  (x_axis),
        .out_degen (x_degen)
    );

    logic [3*ZW:0]          z_line_in;
    logic [3*ZW:0]          z_line_out;
    logic signed [ZW-1:0]   z_d [3];
    logic                   z_degen_d;

    assign z_line_in = {z_degen, z_axis[2], z_axis[1], z_axis[0]};

    lav_delay #(.W(3 * ZW + 1), .D(Z_DLY)) u_dly_z (
        .clk  (clk),
        .din  (z_line_in),
        .dout (z_line_out)
    );

    assign z_d[0]    = signed'(z_line_out[ZW-1:0]);
    assign z_d[1]    = signed'(z_line_out[2*ZW-1:ZW]);
    assign z_d[2]    = signed'(z_line_out[3*ZW-1:2*ZW]);
    assign z_degen_d = z_line_out[3*ZW];

    // True up axis backward x right.
    logic signed [YPW-1:0]  yp_reg [6];
    logic signed [ZW-1:0]   x1_reg [3];
    logic signed [ZW-1:0]   z1_reg [3];
    logic                   dg1_reg;
    logic                   y1_valid_reg;

    logic signed [AW-1:0]   ax2_reg [3][3];
    logic                   dg2_reg;
    logic                   y2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_valid_reg <= 1'b0;
            y2_valid_reg <= 1'b0;
        end else begin
            y1_valid_reg <= x_valid;
            y2_valid_reg <= y1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        yp_reg[0] <= YPW'(z_d[1]) * YPW'(x_axis[2]);
        yp_reg[1] <= YPW'(z_d[2]) * YPW'(x_axis[1]);
        yp_reg[2] <= YPW'(z_d[2]) * YPW'(x_axis[0]);
        yp_reg[3] <= YPW'(z_d[0]) * YPW'(x_axis[2]);
        yp_reg[4] <= YPW'(z_d[0]) * YPW'(x_axis[1]);
        yp_reg[5] <= YPW'(z_d[1]) * YPW'(x_axis[0]);
        x1_reg    <= x_axis;
        z1_reg    <= z_d;
        dg1_reg   <= z_degen_d || x_degen;
        for (int i = 0; i < 3; i++)
        begin
            ax2_reg[lav_pkg::ROW_RIGHT][i] <= AW'(x1_reg[i]);
            ax2_reg[lav_pkg::ROW_BACK][i]  <= AW'(z1_reg[i]);
            ax2_reg[lav_pkg::ROW_UP][i]    <=
                AW'((YSW'(yp_reg[2*i]) - YSW'(yp_reg[2*i+1]) + Y_HALF) >>> F);
        end
        dg2_reg <= dg1_reg;
    end

    // Translation: exact dot with eye, split into two halves of eye.
    logic [3*CW-1:0]        eye_line_in;
    logic [3*CW-1:0]        eye_line_out;
    logic signed [CW-1:0]   eye_d [3];

    assign eye_line_in = {eye_reg[2], eye_reg[1], eye_reg[0]};

    lav_delay #(.W(3 * CW), .D(EYE_DLY)) u_dly_eye (
        .clk  (clk),
        .din  (eye_line_in),
        .dout (eye_line_out)
    );

    assign eye_d[0] = signed'(eye_line_out[CW-1:0]);
    assign eye_d[1] = signed'(eye_line_out[2*CW-1:CW]);
    assign eye_d[2] = signed'(eye_line_out[3*CW-1:2*CW]);

    logic signed [PLW-1:0]  pl_reg [3][3];
    logic signed [PHW-1:0]  ph_reg [3][3];
    logic [FW-1:0]          el3_reg [3][3];
    logic                   dg3_reg;
    logic                   d1_valid_reg;

    logic signed [DOTW-1:0] sum_reg [3];
    logic [FW-1:0]          el4_reg [3][3];
    logic                   dg4_reg;
    logic                   d2_valid_reg;

    logic [FW-1:0]          tr5_reg [3];
    logic [FW-1:0]          el5_reg [3][3];
    logic                   dg5_reg;
    logic                   d3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
        end else begin
            d1_valid_reg <= y2_valid_reg;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [DOTW-1:0] acc;
        logic signed [DOTW-1:0] rnd;
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[r][i]  <= PLW'(ax2_reg[r][i])
                                 * PLW'(signed'({1'b0, eye_d[i][EL-1:0]}));
                ph_reg[r][i]  <= PHW'(ax2_reg[r][i]) * PHW'(signed'(eye_d[i][CW-1:EL]));
                el3_reg[r][i] <= to_field(sat_coord(SATW'(ax2_reg[r][i])));
            end
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                acc = acc + (DOTW'(ph_reg[r][i]) <<< EL) + DOTW'(pl_reg[r][i]);
            end
            sum_reg[r] <= acc;
            rnd = (sum_reg[r] + DOT_HALF) >>> F;
            tr5_reg[r] <= to_field(sat_coord(-SATW'(rnd)));
        end
        el4_reg <= el3_reg;
        el5_reg <= el4_reg;
        dg3_reg <= dg2_reg;
        dg4_reg <= dg3_reg;
        dg5_reg <= dg4_reg;
    end

    // Row sequencer: four beats, one per cycle.
    logic [FW-1:0]          hold_reg [NR][4];
    logic                   hdg_reg;
    logic                   active_reg;
    lav_pkg::row_t          cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= lav_pkg::ROW_RIGHT;
        end else if (d3_valid_reg)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= lav_pkg::ROW_RIGHT;
        end else if (active_reg)
        begin
            if (cnt_reg == lav_pkg::ROW_CONST)
            begin
                active_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d3_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hold_reg[r][i] <= el5_reg[r][i];
                end
                hold_reg[r][3] <= tr5_reg[r];
            end
            hold_reg[lav_pkg::ROW_CONST][0] <= '0;
            hold_reg[lav_pkg::ROW_CONST][1] <= '0;
            hold_reg[lav_pkg::ROW_CONST][2] <= '0;
            hold_reg[lav_pkg::ROW_CONST][3] <= to_field(signed'(ONE_SAT));
            hdg_reg <= dg5_reg;
        end
    end

    assign row_valid  = active_reg;
    assign row_index  = cnt_reg;
    assign elem_0     = signed'(hold_reg[cnt_reg][0]);
    assign elem_1     = signed'(hold_reg[cnt_reg][1]);
    assign elem_2     = signed'(hold_reg[cnt_reg][2]);
    assign elem_3     = signed'(hold_reg[cnt_reg][3]);
    assign degenerate = hdg_reg;
    assign last_row   = (cnt_reg == lav_pkg::ROW_CONST);

endmodule
